FILE: sv/rbk_pkg.sv
// ----------------------------------------------------------------------------
// rbk_pkg
// shared constants, types, rounding helpers and payoff helper of the trinomial rollback unit
// ----------------------------------------------------------------------------
package rbk_pkg;

  localparam int MaxSteps  = 256;
  localparam int PriceBits = 48;
  localparam int NodeDepth = 2 * MaxSteps + 1;
  localparam int IdxW      = $clog2(NodeDepth);
  localparam int AccW      = 84;
  localparam int ProbW     = 33;
  localparam int OpW       = 32;
  localparam int StepW     = 9;

  localparam logic [2:0] RegStepCount = 3'd0;

  typedef struct packed {
    logic vld;
    logic hi;
    logic clr;
  } mac_ctl_t;

  typedef struct packed {
    logic                 sat;
    logic [PriceBits-1:0] val;
  } rnd_t;

  function automatic rnd_t rnd32(input logic [AccW-1:0] acc);
    logic [AccW-1:0] t;
    rnd_t r;
    t = acc + (AccW'(1) << 31);
    r.sat = |t[AccW-1:32+PriceBits];
    r.val = r.sat ? {PriceBits{1'b1}} : t[32+PriceBits-1:32];
    return r;
  endfunction

  function automatic rnd_t rnd28(input logic [AccW-1:0] acc);
    logic [AccW-1:0] t;
    rnd_t r;
    t = acc + (AccW'(1) << 27);
    r.sat = |t[AccW-1:28+PriceBits];
    r.val = r.sat ? {PriceBits{1'b1}} : t[28+PriceBits-1:28];
    return r;
  endfunction

  function automatic logic [PriceBits-1:0] payoff(input logic [PriceBits-1:0] s,
                                                  input logic [PriceBits-1:0] k,
                                                  input logic put);
    logic [PriceBits-1:0] r;
    if (put) r = (k > s) ? k - s : '0;
    else     r = (s > k) ? s - k : '0;
    return r;
  endfunction

endpackage

FILE: sv/rbk_ram.sv
// ----------------------------------------------------------------------------
// rbk_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module rbk_ram #(
  parameter int Width = 48,
  parameter int Depth = 513
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/rbk_mac.sv
// ----------------------------------------------------------------------------
// rbk_mac
// 33x32 multiplier with registered product and wide accumulator
// ----------------------------------------------------------------------------
module rbk_mac import rbk_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  mac_ctl_t        ctl_i,
  input  logic [ProbW-1:0] a_i,
  input  logic [OpW-1:0]   b_i,
  output logic [AccW-1:0]  acc_o
);

  logic [ProbW+OpW-1:0] prod_q;
  mac_ctl_t             ctl_q;
  logic [AccW-1:0]      acc_q, acc_d, term;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
    acc_q  <= acc_d;
  end

  always_comb begin
    term  = ctl_q.hi ? (AccW'(prod_q) << 32) : AccW'(prod_q);
    acc_d = acc_q;
    if (ctl_q.vld) acc_d = (ctl_q.clr ? '0 : acc_q) + term;
  end

  assign acc_o = acc_q;

endmodule

FILE: sv/trinomial_tree_option_rollback_unit.sv
// ----------------------------------------------------------------------------
// trinomial_tree_option_rollback_unit
// prices one option per word on a trinomial lattice held in two node rams
// ----------------------------------------------------------------------------
// One option is priced at a time. With N the step count, the unit first fills
// the 2N+1 terminal nodes and then rolls the lattice back level by level.
// Both phases run on the single shared 33x32 multiplier, which works through
// six partial products of the branch sum and two of the discount for every
// node. The input is taken again as soon as a result is parked in the output
// register.
module trinomial_tree_option_rollback_unit import rbk_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // lowest_node_price, node_ratio, strike_price, barrier_level, rebate_value,
  // prob_up, prob_mid, prob_down, step_discount, zero pad
  input  logic [359:0] s_axis_tdata_i,
  // is_put, early_exercise, barrier_on
  input  logic [2:0]   s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // option_value
  output logic [47:0]  m_axis_tdata_o,
  // saturated
  output logic         m_axis_tuser_o
);

  typedef enum logic [12:0] {
    ST_IDLE    = 13'b0000000000001,
    ST_FILL_LO = 13'b0000000000010,
    ST_FILL_HI = 13'b0000000000100,
    ST_FILL_W  = 13'b0000000001000,
    ST_FILL_NX = 13'b0000000010000,
    ST_LV_RD0  = 13'b0000000100000,
    ST_LV_RD1  = 13'b0000001000000,
    ST_LV_RD2  = 13'b0000010000000,
    ST_ND_RD   = 13'b0000100000000,
    ST_ND_LD   = 13'b0001000000000,
    ST_ND_MUL  = 13'b0010000000000,
    ST_ND_DMUL = 13'b0100000000000,
    ST_DONE    = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;

  logic [StepW-1:0]     step_count_q, step_count_d;
  logic [StepW-1:0]     n_q, n_d;
  logic [IdxW-1:0]      cnt_q, cnt_d, i_q, i_d;
  logic [StepW-1:0]     lvl_q, lvl_d;
  logic [2:0]           step_q, step_d;
  logic                 sat_q, sat_d, out_vld_q, out_vld_d, done_rd_q, done_rd_d;
  logic                 out_sat_q, out_sat_d;
  logic [PriceBits-1:0] s_q, s_d, out_q, out_d;
  logic [PriceBits-1:0] prev_q, prev_d, cur_q, cur_d, up_q, up_d, sp_q, sp_d;
  logic [PriceBits-1:0] inner_q, inner_d;
  logic [PriceBits-1:0] strike_q, strike_d, barrier_q, barrier_d;
  logic [PriceBits-1:0] rebate_q, rebate_d;
  logic [OpW-1:0]       ratio_q, ratio_d;
  logic [ProbW-1:0]     pu_q, pu_d, pm_q, pm_d, pd_q, pd_d, disc_q, disc_d;
  logic                 put_q, put_d, amer_q, amer_d, bon_q, bon_d;

  logic                 accept, cfg_wr, we;
  logic [IdxW-1:0]      waddr, raddr;
  logic [PriceBits-1:0] wval, vrdata, prdata_mem;
  mac_ctl_t             mac_ctl;
  logic [ProbW-1:0]     mac_a;
  logic [OpW-1:0]       mac_b;
  logic [AccW-1:0]      acc;
  rnd_t                 r28, r32;
  logic [PriceBits-1:0] v_fin, ex;
  logic [StepW-1:0]     n_eff;
  logic [IdxW-1:0]      lvl_ext, lvl_nx;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == RegStepCount);
  assign prdata = (paddr == RegStepCount) ? 32'(step_count_q) : '0;
  assign step_count_d = cfg_wr ? pwdata[StepW-1:0] : step_count_q;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_q;
  assign m_axis_tuser_o  = out_sat_q;

  assign n_eff   = (step_count_q == '0) ? StepW'(1) :
                   (step_count_q > StepW'(MaxSteps)) ? StepW'(MaxSteps) : step_count_q;
  assign r28     = rnd28(acc);
  assign r32     = rnd32(acc);
  assign lvl_ext = IdxW'(lvl_q);
  assign lvl_nx  = lvl_ext + IdxW'(1);

  always_comb begin
    ex    = payoff(sp_q, strike_q, put_q);
    v_fin = r32.val;
    if (bon_q && sp_q >= barrier_q) v_fin = rebate_q;
    else if (amer_q && ex > r32.val) v_fin = ex;
  end

  rbk_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mac_ctl),
    .a_i    (mac_a),
    .b_i    (mac_b),
    .acc_o  (acc)
  );

  rbk_ram #(.Width(PriceBits), .Depth(NodeDepth)) u_values (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wval),
    .raddr_i (raddr),
    .rdata_o (vrdata)
  );

  rbk_ram #(.Width(PriceBits), .Depth(NodeDepth)) u_prices (
    .clk_i   (clk_i),
    .we_i    (we && (state_q == ST_FILL_LO)),
    .waddr_i (waddr),
    .wdata_i (s_q),
    .raddr_i (raddr),
    .rdata_o (prdata_mem)
  );

  always_comb begin
    state_d = state_q;
    n_d = n_q; cnt_d = cnt_q; i_d = i_q; lvl_d = lvl_q; step_d = step_q;
    sat_d = sat_q; out_vld_d = out_vld_q; out_d = out_q; done_rd_d = done_rd_q;
    out_sat_d = out_sat_q;
    s_d = s_q; prev_d = prev_q; cur_d = cur_q; up_d = up_q; sp_d = sp_q;
    inner_d = inner_q;
    ratio_d = ratio_q; strike_d = strike_q; barrier_d = barrier_q;
    rebate_d = rebate_q; pu_d = pu_q; pm_d = pm_q; pd_d = pd_q; disc_d = disc_q;
    put_d = put_q; amer_d = amer_q; bon_d = bon_q;
    we = 1'b0; waddr = i_q; wval = '0; raddr = i_q;
    mac_ctl = '0; mac_a = {1'b0, ratio_q}; mac_b = s_q[31:0];

    if (out_vld_q && m_axis_tready_i) out_vld_d = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          ratio_d   = s_axis_tdata_i[79:48];
          strike_d  = s_axis_tdata_i[127:80];
          barrier_d = s_axis_tdata_i[175:128];
          rebate_d  = s_axis_tdata_i[223:176];
          pu_d      = s_axis_tdata_i[256:224];
          pm_d      = s_axis_tdata_i[289:257];
          pd_d      = s_axis_tdata_i[322:290];
          disc_d    = s_axis_tdata_i[355:323];
          put_d     = s_axis_tuser_i[0];
          amer_d    = s_axis_tuser_i[1];
          bon_d     = s_axis_tuser_i[2];
          s_d       = s_axis_tdata_i[47:0];
          n_d       = n_eff;
          cnt_d     = {n_eff, 1'b1};
          i_d       = '0;
          lvl_d     = '0;
          sat_d     = 1'b0;
          state_d   = ST_FILL_LO;
        end
      end
      ST_FILL_LO: begin
        we   = 1'b1;
        wval = (bon_q && s_q >= barrier_q) ? rebate_q : payoff(s_q, strike_q, put_q);
        mac_ctl = '{vld: 1'b1, hi: 1'b0, clr: 1'b1};
        state_d = ST_FILL_HI;
      end
      ST_FILL_HI: begin
        mac_b   = OpW'(s_q[PriceBits-1:32]);
        mac_ctl = '{vld: 1'b1, hi: 1'b1, clr: 1'b0};
        state_d = ST_FILL_W;
      end
      ST_FILL_W: state_d = ST_FILL_NX;
      ST_FILL_NX: begin
        s_d   = r28.val;
        sat_d = sat_q | r28.sat;
        i_d   = i_q + IdxW'(1);
        state_d = (i_d == cnt_q) ? ST_LV_RD0 : ST_FILL_LO;
      end
      ST_LV_RD0: begin
        raddr   = lvl_ext;
        state_d = ST_LV_RD1;
      end
      ST_LV_RD1: begin
        prev_d  = vrdata;
        raddr   = lvl_nx;
        state_d = ST_LV_RD2;
      end
      ST_LV_RD2: begin
        raddr   = lvl_nx;
        i_d     = lvl_nx;
        state_d = ST_ND_RD;
      end
      ST_ND_RD: begin
        if (i_q == lvl_nx && cur_q != vrdata) cur_d = vrdata;
        if (i_q == lvl_nx) cur_d = vrdata;
        raddr   = i_q + IdxW'(1);
        state_d = ST_ND_LD;
      end
      ST_ND_LD: begin
        raddr   = i_q;
        up_d    = vrdata;
        step_d  = '0;
        state_d = ST_ND_MUL;
      end
      ST_ND_MUL: begin
        if (step_q == 3'd1) sp_d = prdata_mem;
        case (step_q)
          3'd0: begin mac_a = pu_q; mac_b = up_q[31:0]; end
          3'd1: begin mac_a = pu_q; mac_b = OpW'(up_q[PriceBits-1:32]); end
          3'd2: begin mac_a = pm_q; mac_b = cur_q[31:0]; end
          3'd3: begin mac_a = pm_q; mac_b = OpW'(cur_q[PriceBits-1:32]); end
          3'd4: begin mac_a = pd_q; mac_b = prev_q[31:0]; end
          default: begin mac_a = pd_q; mac_b = OpW'(prev_q[PriceBits-1:32]); end
        endcase
        mac_ctl = '{vld: (step_q < 3'd6), hi: step_q[0], clr: (step_q == 3'd0)};
        step_d  = step_q + 3'd1;
        if (step_q == 3'd7) begin
          inner_d = r32.val;
          sat_d   = sat_q | r32.sat;
          step_d  = '0;
          state_d = ST_ND_DMUL;
        end
      end
      ST_ND_DMUL: begin
        mac_a   = disc_q;
        mac_b   = step_q[0] ? OpW'(inner_q[PriceBits-1:32]) : inner_q[31:0];
        mac_ctl = '{vld: (step_q < 3'd2), hi: step_q[0], clr: (step_q == 3'd0)};
        step_d  = step_q + 3'd1;
        if (step_q == 3'd3) begin
          we     = 1'b1;
          wval   = v_fin;
          sat_d  = sat_q | r32.sat;
          prev_d = cur_q;
          cur_d  = up_q;
          i_d    = i_q + IdxW'(1);
          if ((i_d + lvl_nx) < cnt_q) begin
            state_d = ST_ND_RD;
          end else begin
            lvl_d = lvl_q + StepW'(1);
            if (lvl_d == n_q) begin
              done_rd_d = 1'b0;
              state_d   = ST_DONE;
            end else begin
              state_d = ST_LV_RD0;
            end
          end
        end
      end
      ST_DONE: begin
        raddr     = IdxW'(n_q);
        done_rd_d = 1'b1;
        if (done_rd_q && !out_vld_q) begin
          out_d     = vrdata;
          out_sat_d = sat_q;
          out_vld_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      step_count_q <= StepW'(1);
      lvl_q        <= '0;
      out_vld_q    <= 1'b0;
      done_rd_q    <= 1'b0;
      step_q       <= '0;
      i_q          <= '0;
      n_q          <= StepW'(1);
      cnt_q        <= IdxW'(3);
    end else begin
      state_q      <= state_d;
      step_count_q <= step_count_d;
      lvl_q        <= lvl_d;
      out_vld_q    <= out_vld_d;
      done_rd_q    <= done_rd_d;
      step_q       <= step_d;
      i_q          <= i_d;
      n_q          <= n_d;
      cnt_q        <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sat_q <= sat_d; out_q <= out_d; out_sat_q <= out_sat_d; s_q <= s_d;
    prev_q <= prev_d; cur_q <= cur_d; up_q <= up_d; sp_q <= sp_d; inner_q <= inner_d;
    ratio_q <= ratio_d; strike_q <= strike_d; barrier_q <= barrier_d;
    rebate_q <= rebate_d; pu_q <= pu_d; pm_q <= pm_d; pd_q <= pd_d; disc_q <= disc_d;
    put_q <= put_d; amer_q <= amer_d; bon_q <= bon_d;
  end

  a_accept_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == ST_FILL_LO)
    else $error("accepted word did not start the fill");

  a_write_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> i_q < cnt_q)
    else $error("node write beyond lattice");

  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ND_MUL) |-> (lvl_q < n_q) && (i_q > lvl_ext))
    else $error("rollback node outside current level");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !m_axis_tready_i) |=> out_vld_q && $stable(out_q))
    else $error("pending result lost");

endmodule
